// ===== sv/lkvc_pkg.sv =====
package lkvc_pkg;

  // Command codes carried on cmd_i.
  localparam logic [1:0] CMD_RETRIEVE = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_EXISTS   = 2'd2;

  // Sequencing commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the accepted item
    logic look;   // key compare and slot selection
    logic exec;   // apply updates and load the result
  } ctrl_cmd_t;

endpackage

// ===== sv/lkvc_ram.sv =====
module lkvc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lkvc_ctrl.sv =====
module lkvc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output lkvc_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_LOOK;
      S_LOOK: state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign done_d = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign cmd_o.latch = start_i && (state_q == S_IDLE);
  assign cmd_o.look  = (state_q == S_LOOK);
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

// ===== sv/lkvc_datapath.sv =====
module lkvc_datapath #(
  parameter int Entries   = 16,
  parameter int KeyBits   = 32,
  parameter int ValueBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_pkg::ctrl_cmd_t cmd_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic [1:0]          item_cmd_i,
  input  logic [31:0]         item_key_i,
  input  logic [31:0]         item_value_i,
  output logic                found_o,
  output logic [31:0]         data_o,
  output logic                evicted_o,
  output logic [4:0]          occupancy_o
);

  localparam int KW   = (KeyBits < 32) ? KeyBits : 32;
  localparam int VW   = (ValueBits < 32) ? ValueBits : 32;
  localparam int SW   = $clog2(Entries);
  localparam int CW   = $clog2(Entries + 1);
  localparam int CapW = (CW > 5) ? CW : 5;

  logic [1:0]    cmd_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;

  logic [KW-1:0] keys_q [Entries];
  logic          valid_q [Entries];
  logic [SW-1:0] rank_q [Entries];
  logic [CW-1:0] count_q;
  logic [CW-1:0] cap_q;

  logic          hit_q, full_q;
  logic [SW-1:0] slot_q, slot_rank_q;

  logic          hit_d;
  logic [SW-1:0] hit_idx, lru_idx, free_idx, slot_d, slot_rank_d;
  logic          full_d;

  logic          is_add, do_touch, do_insert, do_evict;
  logic [VW-1:0] rdata;

  logic          found_q, evicted_q;
  logic [31:0]   data_q;
  logic [CW-1:0] occ_q;
  logic [CW+4:0] occ_ext;

  logic [CapW-1:0] cfg_ext;
  logic [CapW-1:0] cap_sat;

  // Capacity saturates to 1..Entries on write.
  always_comb begin
    cfg_ext = CapW'(cfg_wdata_i);
    if (cfg_ext == '0) begin
      cap_sat = CapW'(1);
    end else if (cfg_ext > CapW'(Entries)) begin
      cap_sat = CapW'(Entries);
    end else begin
      cap_sat = cfg_ext;
    end
  end

  // Parallel compare against every entry; the lowest matching, free and
  // oldest slots are picked out by priority scans.
  always_comb begin
    hit_d    = 1'b0;
    hit_idx  = '0;
    lru_idx  = '0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && (keys_q[i] == key_q)) begin
        hit_d   = 1'b1;
        hit_idx = SW'(i);
      end
      if (valid_q[i] && (CW'(rank_q[i]) == count_q - CW'(1))) begin
        lru_idx = SW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  assign full_d = (count_q >= cap_q);

  always_comb begin
    if (hit_d) begin
      slot_d = hit_idx;
    end else if (full_d) begin
      slot_d = lru_idx;
    end else begin
      slot_d = free_idx;
    end
    slot_rank_d = '0;
    for (int i = 0; i < Entries; i++) begin
      if (slot_d == SW'(i)) slot_rank_d = rank_q[i];
    end
  end

  assign is_add    = (cmd_q == lkvc_pkg::CMD_ADD);
  assign do_evict  = is_add && !hit_q && full_q;
  assign do_insert = is_add && !hit_q && !full_q;
  assign do_touch  = (hit_q && (cmd_q == lkvc_pkg::CMD_RETRIEVE || is_add)) || do_evict;

  lkvc_ram #(
    .Width(VW),
    .Depth(Entries)
  ) u_values (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && is_add),
    .waddr_i(slot_q),
    .wdata_i(val_q),
    .raddr_i(hit_idx),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= item_cmd_i;
      key_q <= item_key_i[KW-1:0];
      val_q <= item_value_i[VW-1:0];
    end
    if (cmd_i.look) begin
      hit_q       <= hit_d;
      full_q      <= full_d;
      slot_q      <= slot_d;
      slot_rank_q <= slot_rank_d;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < Entries; i++) begin
        if (is_add && !hit_q && slot_q == SW'(i)) keys_q[i] <= key_q;
      end
      found_q   <= hit_q && (cmd_q == lkvc_pkg::CMD_RETRIEVE || is_add ||
                             cmd_q == lkvc_pkg::CMD_EXISTS);
      data_q    <= (hit_q && cmd_q == lkvc_pkg::CMD_RETRIEVE) ? 32'(rdata) : '0;
      evicted_q <= do_evict;
      occ_q     <= count_q + CW'(do_insert);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
      count_q <= '0;
      cap_q   <= CW'(Entries);
    end else begin
      if (cfg_we_i) begin
        cap_q <= CW'(cap_sat);
      end
      if (cmd_i.exec) begin
        for (int i = 0; i < Entries; i++) begin
          if (do_touch) begin
            if (slot_q == SW'(i)) begin
              rank_q[i] <= '0;
            end else if (valid_q[i] && rank_q[i] < slot_rank_q) begin
              rank_q[i] <= rank_q[i] + SW'(1);
            end
          end else if (do_insert) begin
            if (slot_q == SW'(i)) begin
              rank_q[i]  <= '0;
              valid_q[i] <= 1'b1;
            end else if (valid_q[i]) begin
              rank_q[i] <= rank_q[i] + SW'(1);
            end
          end
        end
        if (do_insert) begin
          count_q <= count_q + CW'(1);
        end
      end
    end
  end

  assign occ_ext     = (CW + 5)'(occ_q);
  assign found_o     = found_q;
  assign data_o      = data_q;
  assign evicted_o   = evicted_q;
  assign occupancy_o = occ_ext[4:0];

endmodule

// ===== sv/lru_key_value_cache_top.sv =====
// Fully associative key/value cache with least-recently-used replacement.
// An item is taken when start_i is high and busy_o is low; its result is
// shown for exactly one cycle under done_o after the look and exec steps,
// and the receiver cannot hold it off. No item is taken while busy_o is
// high: look compares the key against all entries in parallel, picks the
// slot and addresses the value memory (registered read); exec uses the read
// value and applies the recency, key and value updates; the registered
// result is then presented while a new item may already be taken. Capacity
// is written through cfg_we_i/cfg_wdata_i and saturated to 1..ENTRIES; the
// user must write it only while the block is idle; it does not enforce this.
module lru_key_value_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic        found_o,
  output logic [31:0] data_o,
  output logic        evicted_o,
  output logic [4:0]  occupancy_o
);

  lkvc_pkg::ctrl_cmd_t ctrl_cmd;

  lkvc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (ctrl_cmd)
  );

  lkvc_datapath #(
    .Entries  (ENTRIES),
    .KeyBits  (KEY_BITS),
    .ValueBits(VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_cmd_i  (cmd_i),
    .item_key_i  (key_i),
    .item_value_i(value_i),
    .found_o     (found_o),
    .data_o      (data_o),
    .evicted_o   (evicted_o),
    .occupancy_o (occupancy_o)
  );

  // An accepted item keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after an item was accepted");

  // Results are never on two adjacent cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // Data is zero unless the key was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> data_o == '0)
    else $error("nonzero data on a miss");

  // An eviction only happens when the key was absent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> !found_o)
    else $error("eviction reported on a hit");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;
  localparam int KEY_POOL = 24;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTED = 50;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic        found;
    logic [31:0] data;
    logic        evicted;
    logic [4:0]  occupancy;
  } cache_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  cmd_i = lkvc_pkg::CMD_RETRIEVE;
  logic [31:0] key_i = '0;
  logic [31:0] value_i = '0;
  logic        done_o;
  logic        found_o;
  logic [31:0] data_o;
  logic        evicted_o;
  logic [4:0]  occupancy_o;

  // Shadow copy of the cache contents and its configuration.
  logic [31:0] shadow_key [ENTRIES];
  logic [31:0] shadow_value [ENTRIES];
  bit          shadow_valid [ENTRIES];
  int unsigned shadow_rank [ENTRIES];
  int unsigned shadow_count = 0;
  int unsigned shadow_capacity = ENTRIES;

  cache_result_t pending_results[$];
  logic [31:0]   key_pool [KEY_POOL];
  int            error_count = 0;
  int            stall_cycles = 0;

  lru_key_value_cache_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .data_o      (data_o),
    .evicted_o   (evicted_o),
    .occupancy_o (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Moves one entry to the front; valid entries that were more recent age by one.
  function automatic void make_most_recent(input int slot);
    int unsigned old_rank;
    old_rank = shadow_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && i != slot && shadow_rank[i] < old_rank) begin
        shadow_rank[i]++;
      end
    end
    shadow_rank[slot] = 0;
  endfunction

  function automatic cache_result_t predict_cache(input logic [1:0] cmd, input logic [31:0] key,
                                                  input logic [31:0] value);
    cache_result_t res;
    bit            hit;
    bit            any;
    int            slot;
    int unsigned   worst;
    res = '0;
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit && shadow_valid[i] && shadow_key[i] == key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    case (cmd)
      lkvc_pkg::CMD_RETRIEVE: begin
        if (hit) begin
          res.data = shadow_value[slot];
          make_most_recent(slot);
        end
      end
      lkvc_pkg::CMD_ADD: begin
        if (hit) begin
          shadow_value[slot] = value;
          make_most_recent(slot);
        end else if (shadow_count >= shadow_capacity || shadow_count >= ENTRIES) begin
          // Store full for the current capacity: the least recent entry is replaced.
          any = 1'b0;
          worst = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_valid[i] && (!any || shadow_rank[i] > worst)) begin
              worst = shadow_rank[i];
              slot = i;
              any = 1'b1;
            end
          end
          if (any) begin
            res.evicted = 1'b1;
            shadow_key[slot] = key;
            shadow_value[slot] = value;
            make_most_recent(slot);
          end
        end else begin
          slot = ENTRIES;
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!shadow_valid[i]) begin
              slot = i;
            end
          end
          if (slot < ENTRIES) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (shadow_valid[i]) begin
                shadow_rank[i]++;
              end
            end
            shadow_valid[slot] = 1'b1;
            shadow_key[slot] = key;
            shadow_value[slot] = value;
            shadow_rank[slot] = 0;
            shadow_count++;
          end
        end
      end
      lkvc_pkg::CMD_EXISTS: begin
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    res.found = hit;
    res.occupancy = 5'(shadow_count);
    return res;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] key,
                           input logic [31:0] value);
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= cmd;
    key_i <= key;
    value_i <= value;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_cache(cmd, key, value));
  endtask

  task automatic idle_burst(input int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stops sending and lets every outstanding result arrive before going on.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (value < 1) begin
      shadow_capacity = 1;
    end else if (value > ENTRIES) begin
      shadow_capacity = ENTRIES;
    end else begin
      shadow_capacity = 32'(value);
    end
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 7) begin
      return key_pool[$urandom_range(0, KEY_POOL - 1)];
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      return lkvc_pkg::CMD_RETRIEVE;
    end else if (roll < 75) begin
      return lkvc_pkg::CMD_ADD;
    end else if (roll < 95) begin
      return lkvc_pkg::CMD_EXISTS;
    end
    return CMD_UNUSED;
  endfunction

  task automatic run_random(input int count, input bit with_gaps);
    for (int n = 0; n < count; n++) begin
      if (with_gaps && $urandom_range(0, 3) == 0) begin
        idle_burst($urandom_range(1, 19));
      end
      send_item(pick_cmd(), pick_key(), $urandom());
    end
  endtask

  task automatic test_directed();
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h0, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::CMD_EXISTS, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_UNUSED, 32'h0, 32'h1234_5678);
    send_item(lkvc_pkg::CMD_ADD, 32'h0, 32'h0);
    send_item(lkvc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'hFFFF_FFFF, 32'h0);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h0, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::CMD_ADD, 32'h0, 32'hA5A5_A5A5);
    send_item(lkvc_pkg::CMD_EXISTS, 32'h0, 32'h0);
    // The unused command must report a miss even for a stored key.
    send_item(CMD_UNUSED, 32'h0, 32'h0);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h8000_0001, 32'h0);
  endtask

  task automatic test_capacity_saturation();
    // A written zero acts as one; the store already holds more than that.
    write_capacity(5'd0);
    send_item(lkvc_pkg::CMD_ADD, 32'h1234_5678, 32'h5A5A_5A5A);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h1234_5678, 32'h0);
    send_item(lkvc_pkg::CMD_ADD, 32'h1234_5678, 32'h0F0F_0F0F);
    send_item(lkvc_pkg::CMD_ADD, 32'h0, 32'h3C3C_3C3C);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h0, 32'h0);
    write_capacity(5'd1);
    send_item(lkvc_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
    // Values above the entry count saturate, so there is free room again.
    write_capacity(5'd31);
    send_item(lkvc_pkg::CMD_ADD, 32'hDEAD_BEEF, 32'h0000_0001);
    send_item(lkvc_pkg::CMD_EXISTS, 32'hDEAD_BEEF, 32'h0);
    send_item(lkvc_pkg::CMD_RETRIEVE, 32'h7FFF_FFFF, 32'h0);
  endtask

  task automatic test_growing_capacity();
    write_capacity(5'd2);
    run_random(40, 1'b1);
    write_capacity(5'd4);
    run_random(40, 1'b1);
    write_capacity(5'd7);
    run_random(40, 1'b1);
    write_capacity(5'd10);
    run_random(40, 1'b1);
    write_capacity(5'd16);
    run_random(40, 1'b1);
  endtask

  task automatic test_capacity_below_occupancy();
    write_capacity(5'd5);
    run_random(65, 1'b1);
    write_capacity(5'($urandom_range(0, 31)));
    run_random(40, 1'b1);
  endtask

  task automatic test_sender_drain();
    write_capacity(5'd17);
    run_random(30, 1'b1);
    wait_idle();
    run_random(30, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_random(60, 1'b0);
  endtask

  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_error("result with no item pending");
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found) begin
          report_error($sformatf("found %0b, expected %0b", found_o, want.found));
        end
        if (data_o !== want.data) begin
          report_error($sformatf("data %h, expected %h", data_o, want.data));
        end
        if (evicted_o !== want.evicted) begin
          report_error($sformatf("evicted %0b, expected %0b", evicted_o, want.evicted));
        end
        if (occupancy_o !== want.occupancy) begin
          report_error($sformatf("occupancy %0d, expected %0d", occupancy_o,
                                 want.occupancy));
        end
      end
    end
  end

  // Ends the run when nothing is taken or returned for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom();
    end
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_capacity_saturation();
    test_growing_capacity();
    test_capacity_below_occupancy();
    test_sender_drain();
    test_back_to_back();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lkvc_pkg.sv
sv/lkvc_ram.sv
sv/lkvc_ctrl.sv
sv/lkvc_datapath.sv
sv/lru_key_value_cache_top.sv
tb/testbench.sv
